FILE: src/lpm_pkg.sv
// Shared types and constants for the layer priority mixer.
// Used by the register block, the resolver, the top level and the checker.
`timescale 1ns / 1ps

package lpm_pkg;

   localparam int NUM_LAYERS  = 5;
   localparam int LEVEL_W     = 6;
   localparam int PIX_W       = 9;
   localparam int LAYER_W     = 3;
   localparam int PAL_W       = 7;
   localparam int SHADOW_W    = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;

   // Register indexes, taken from paddr[4:2].
   localparam logic [2:0] REG_LEVELS     = 3'd0;
   localparam logic [2:0] REG_SHADOW     = 3'd1;
   localparam logic [2:0] REG_BANKS_LOW  = 3'd2;
   localparam logic [2:0] REG_BANKS_HIGH = 3'd3;
   localparam logic [2:0] REG_OPACITY    = 3'd4;
   localparam logic [2:0] REG_SRC_ENABLE = 3'd5;

   localparam logic [5:0] LEVEL_MAX = 6'h3F;

   // Shadow select codes.
   localparam logic [1:0] SHADOW_NONE = 2'd0;
   localparam logic [1:0] SHADOW_SEL1 = 2'd1;
   localparam logic [1:0] SHADOW_SEL2 = 2'd2;
   localparam logic [1:0] SHADOW_SEL3 = 2'd3;

   // Layer codes.
   localparam logic [2:0] LAYER0 = 3'd0;
   localparam logic [2:0] LAYER1 = 3'd1;
   localparam logic [2:0] LAYER2 = 3'd2;
   localparam logic [2:0] LAYER3 = 3'd3;
   localparam logic [2:0] LAYER4 = 3'd4;

   // One request, last field in the lowest bits.
   typedef struct packed {
      logic [1:0] shadow_select;
      logic [5:0] ext_priority2;
      logic [5:0] ext_priority1;
      logic [5:0] ext_priority0;
      logic [7:0] layer4_pixel;
      logic [7:0] layer3_pixel;
      logic [8:0] layer2_pixel;
      logic [8:0] layer1_pixel;
      logic [8:0] layer0_pixel;
   } req_type;

   // One result, last field in the lowest bits.
   typedef struct packed {
      logic [1:0] shadow_out;
      logic [6:0] palette_offset;
      logic [5:0] top_priority;
      logic [8:0] top_pixel;
      logic [2:0] top_layer;
   } rsp_type;

   // Configuration seen by the resolver.
   typedef struct packed {
      logic [29:0] levels;
      logic [17:0] shadow_levels;
      logic [5:0]  banks_low;
      logic [5:0]  banks_high;
      logic [5:0]  opacity_swap;
      logic [2:0]  src_enable;
   } cfg_type;

endpackage

FILE: src/lpm_csr.sv
// APB-style configuration registers of the layer priority mixer.
// Depends on lpm_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps

module lpm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lpm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lpm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lpm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output lpm_pkg::cfg_type                  cfg
);

   lpm_pkg::cfg_type cfg_ff;
   lpm_pkg::cfg_type cfg_in;
   logic [2:0]       reg_index;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Next register contents; writes to unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            lpm_pkg::REG_LEVELS:     cfg_in.levels        = csr_pwdata[29:0];
            lpm_pkg::REG_SHADOW:     cfg_in.shadow_levels = csr_pwdata[17:0];
            lpm_pkg::REG_BANKS_LOW:  cfg_in.banks_low     = csr_pwdata[5:0];
            lpm_pkg::REG_BANKS_HIGH: cfg_in.banks_high    = csr_pwdata[5:0];
            lpm_pkg::REG_OPACITY:    cfg_in.opacity_swap  = csr_pwdata[5:0];
            lpm_pkg::REG_SRC_ENABLE: cfg_in.src_enable    = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.levels        <= '1;
         cfg_ff.shadow_levels <= '0;
         cfg_ff.banks_low     <= '0;
         cfg_ff.banks_high    <= '0;
         cfg_ff.opacity_swap  <= '0;
         cfg_ff.src_enable    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      case (reg_index)
         lpm_pkg::REG_LEVELS:     csr_prdata = {2'b0, cfg_ff.levels};
         lpm_pkg::REG_SHADOW:     csr_prdata = {14'b0, cfg_ff.shadow_levels};
         lpm_pkg::REG_BANKS_LOW:  csr_prdata = {26'b0, cfg_ff.banks_low};
         lpm_pkg::REG_BANKS_HIGH: csr_prdata = {26'b0, cfg_ff.banks_high};
         lpm_pkg::REG_OPACITY:    csr_prdata = {26'b0, cfg_ff.opacity_swap};
         lpm_pkg::REG_SRC_ENABLE: csr_prdata = {29'b0, cfg_ff.src_enable};
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/lpm_resolve.sv
// Combinational priority resolution for one pixel of five layers.
// Depends on lpm_pkg for the request, result and configuration structs.
`timescale 1ns / 1ps

module lpm_resolve (
   input  lpm_pkg::req_type req,
   input  lpm_pkg::cfg_type cfg,
   output lpm_pkg::rsp_type rsp
);

   logic [8:0] pix   [lpm_pkg::NUM_LAYERS];
   logic [5:0] pri   [lpm_pkg::NUM_LAYERS];
   logic [2:0] order [lpm_pkg::NUM_LAYERS];
   logic       opaque [lpm_pkg::NUM_LAYERS];
   logic [2:0] win;
   logic [5:0] thresh;
   logic [6:0] pal_offset;

   // Pixel codes, widened to a common width.
   always_comb begin
      pix[0] = req.layer0_pixel;
      pix[1] = req.layer1_pixel;
      pix[2] = req.layer2_pixel;
      pix[3] = {1'b0, req.layer3_pixel};
      pix[4] = {1'b0, req.layer4_pixel};
   end

   // Effective priorities: layers 0-2 take the external value unless enabled.
   always_comb begin
      pri[0] = cfg.src_enable[0] ? cfg.levels[5:0]   : req.ext_priority0;
      pri[1] = cfg.src_enable[1] ? cfg.levels[11:6]  : req.ext_priority1;
      pri[2] = cfg.src_enable[2] ? cfg.levels[17:12] : req.ext_priority2;
      pri[3] = cfg.levels[23:18];
      pri[4] = cfg.levels[29:24];
   end

   // Opacity: low nibble, or the whole low byte when the layer's mode bit is set.
   always_comb begin
      for (int l = 0; l < lpm_pkg::NUM_LAYERS; l++) begin
         if (cfg.opacity_swap[l]) begin
            opaque[l] = (pix[l][7:0] != 8'h0);
         end else begin
            opaque[l] = (pix[l][3:0] != 4'h0);
         end
      end
   end

   // Position order; the first two positions exchange under the swap rule.
   always_comb begin
      order[0] = lpm_pkg::LAYER0;
      order[1] = lpm_pkg::LAYER1;
      order[2] = lpm_pkg::LAYER2;
      order[3] = lpm_pkg::LAYER3;
      order[4] = lpm_pkg::LAYER4;
      if (cfg.opacity_swap[5] && (pri[1] < pri[0])) begin
         order[0] = lpm_pkg::LAYER1;
         order[1] = lpm_pkg::LAYER0;
      end
   end

   // Winner: lowest priority among opaque layers, earlier position on ties.
   // With nothing opaque, the highest priority wins, later position on ties.
   always_comb begin
      logic       found;
      logic [2:0] l;
      found = 1'b0;
      win   = order[0];
      for (int k = 0; k < lpm_pkg::NUM_LAYERS; k++) begin
         l = order[k];
         if (opaque[l] && (!found || (pri[l] < pri[win]))) begin
            win   = l;
            found = 1'b1;
         end
      end
      if (!found) begin
         win = order[0];
         for (int k = 0; k < lpm_pkg::NUM_LAYERS; k++) begin
            l = order[k];
            if (pri[l] >= pri[win]) begin
               win = l;
            end
         end
      end
   end

   // Palette offset of the winning layer.
   always_comb begin
      case (win)
         lpm_pkg::LAYER0: pal_offset = {cfg.banks_low[1:0], 5'b0};
         lpm_pkg::LAYER1: pal_offset = {cfg.banks_low[3:2], 5'b0};
         lpm_pkg::LAYER2: pal_offset = {cfg.banks_low[5:4], 5'b0};
         lpm_pkg::LAYER3: pal_offset = {cfg.banks_high[2:0], 4'b0};
         lpm_pkg::LAYER4: pal_offset = {cfg.banks_high[5:3], 4'b0};
         default:         pal_offset = '0;
      endcase
   end

   // Shadow threshold picked by the shadow select.
   always_comb begin
      case (req.shadow_select)
         lpm_pkg::SHADOW_NONE: thresh = lpm_pkg::LEVEL_MAX;
         lpm_pkg::SHADOW_SEL1: thresh = cfg.shadow_levels[5:0];
         lpm_pkg::SHADOW_SEL2: thresh = cfg.shadow_levels[11:6];
         lpm_pkg::SHADOW_SEL3: thresh = cfg.shadow_levels[17:12];
         default:              thresh = lpm_pkg::LEVEL_MAX;
      endcase
   end

   assign rsp.top_layer      = win;
   assign rsp.top_pixel      = pix[win];
   assign rsp.top_priority   = pri[win];
   assign rsp.palette_offset = pal_offset;
   assign rsp.shadow_out     = (pri[win] < thresh) ? req.shadow_select : lpm_pkg::SHADOW_NONE;

endmodule

FILE: src/layer_priority_mixer.sv
// Top level of the five-layer priority mixer: request register, resolver, result register.
// Depends on lpm_pkg, lpm_csr and lpm_resolve.
`timescale 1ns / 1ps

// Each request carries one pixel from each of five layers and returns one result naming the
// winning layer, its pixel, priority, palette offset and shadow. A request is taken in every
// cycle unless the result register is held by rsp_tready and the request register is full; the
// request passes through the request register and then the result register, and while a result
// waits for rsp_tready the request side keeps accepting only into an empty request register.
// Configuration is written through the APB-style port at byte addresses 0 to 20 and should change
// only while no request is in flight.
module layer_priority_mixer (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: layer0_pixel[8:0], layer1_pixel[17:9], layer2_pixel[26:18],
   // layer3_pixel[34:27], layer4_pixel[42:35], ext_priority0[48:43],
   // ext_priority1[54:49], ext_priority2[60:55], shadow_select[62:61], unused[63].
   input  logic [lpm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: top_layer[2:0], top_pixel[11:3], top_priority[17:12],
   // palette_offset[24:18], shadow_out[26:25], zeros[31:27].
   output logic [lpm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lpm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lpm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lpm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   lpm_pkg::cfg_type cfg;
   lpm_pkg::req_type req_ff;
   lpm_pkg::req_type req_in;
   lpm_pkg::rsp_type rsp_ff;
   lpm_pkg::rsp_type rsp_in;
   lpm_pkg::rsp_type rsp_calc;
   logic             req_valid_ff;
   logic             req_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_advance;

   lpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpm_resolve u_resolve (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_calc)
   );

   // The result register takes a new value when it is empty or being drained.
   assign rsp_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !req_valid_ff || rsp_advance;

   // Next state of both stages.
   always_comb begin
      req_valid_in = req_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
         req_in       = lpm_pkg::req_type'(req_tdata[$bits(lpm_pkg::req_type)-1:0]);
      end
      if (rsp_advance) begin
         rsp_valid_in = req_valid_ff;
         rsp_in       = rsp_calc;
      end
   end

   // Valid flags are reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lpm_pkg::RSP_TDATA_W - $bits(lpm_pkg::rsp_type)){1'b0}}, rsp_ff};

endmodule

FILE: src/lpm_checker.sv
// Port-level assertions for the layer priority mixer, bound to the top level.
// Depends on lpm_pkg for layer codes and field widths.
`timescale 1ns / 1ps

module lpm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lpm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [2:0] top_layer;
   logic [6:0] palette_offset;

   assign top_layer      = rsp_tdata[2:0];
   assign palette_offset = rsp_tdata[24:18];

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The winning layer is always one of the five.
   a_layer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> top_layer <= lpm_pkg::LAYER4)
      else $error("winning layer out of range");

   // Palette offset granularity follows the winning layer group.
   a_palette_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((top_layer < lpm_pkg::LAYER3) ? (palette_offset[4:0] == 5'd0)
                                                    : (palette_offset[3:0] == 4'd0)))
      else $error("palette offset does not match winning layer");

   // An offered request is taken whenever the result register is empty.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !rsp_tvalid |-> req_tready)
      else $error("request refused with empty result register");

endmodule

bind layer_priority_mixer lpm_checker u_lpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/layer_priority_mixer_tb.sv
// Self-checking testbench for the five-layer priority mixer: streams pixel requests, checks results.
// Depends on lpm_pkg and layer_priority_mixer; it carries its own copy of the mixing rules.
`timescale 1ns / 1ps

module layer_priority_mixer_tb;
   import lpm_pkg::*;

   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 48;
   localparam int REPORT_LIMIT   = 30;

   // Register indexes past the last implemented register; writes there are ignored.
   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Requests waiting to be offered, and the mix results they must produce, oldest first.
   req_type pending_pixels[$];
   rsp_type expected_mixes[$];

   // Register values as the block should hold them.
   cfg_type mix_cfg;

   bit burst_mode = 1'b0;
   bit long_hold_req = 1'b0;
   int error_count = 0;
   int request_count = 0;
   int result_count = 0;
   int setting_count = 0;
   int watchdog_cycles = 0;

   layer_priority_mixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Picks the winning layer for one pixel under the current register values.
   function automatic rsp_type resolve_pixel(req_type r);
      logic [8:0] pix [0:4];
      logic [5:0] pri [0:4];
      int         order [0:4];
      int         n;
      int         lyr;
      int         win;
      bit         found;
      logic [7:0] opaque_mask;
      logic [5:0] thresh;
      rsp_type    res;
      pix[0] = r.layer0_pixel;
      pix[1] = r.layer1_pixel;
      pix[2] = r.layer2_pixel;
      pix[3] = {1'b0, r.layer3_pixel};
      pix[4] = {1'b0, r.layer4_pixel};
      for (n = 0; n < NUM_LAYERS; n++) begin
         pri[n] = mix_cfg.levels[LEVEL_W*n +: LEVEL_W];
         order[n] = n;
      end
      if (!mix_cfg.src_enable[0]) pri[0] = r.ext_priority0;
      if (!mix_cfg.src_enable[1]) pri[1] = r.ext_priority1;
      if (!mix_cfg.src_enable[2]) pri[2] = r.ext_priority2;

      // Layers 0 and 1 trade tie-break positions when swapping is on and layer 1 is stronger.
      if (mix_cfg.opacity_swap[5] && pri[1] < pri[0]) begin
         order[0] = 1;
         order[1] = 0;
      end

      // Strongest opaque layer; the earlier position keeps a tie.
      win = order[0];
      found = 1'b0;
      for (n = 0; n < NUM_LAYERS; n++) begin
         lyr = order[n];
         opaque_mask = mix_cfg.opacity_swap[lyr] ? 8'hFF : 8'h0F;
         if ((pix[lyr][7:0] & opaque_mask) != 8'h00) begin
            if (!found || pri[lyr] < pri[win]) begin
               win = lyr;
               found = 1'b1;
            end
         end
      end

      // With nothing opaque, the weakest layer shows; the later position keeps a tie.
      if (!found) begin
         win = order[0];
         for (n = 0; n < NUM_LAYERS; n++) begin
            lyr = order[n];
            if (pri[lyr] >= pri[win]) win = lyr;
         end
      end

      res.top_layer = 3'(win);
      res.top_pixel = pix[win];
      res.top_priority = pri[win];
      if (win < 3) begin
         res.palette_offset = {mix_cfg.banks_low[2*win +: 2], 5'b0};
      end else begin
         res.palette_offset = {mix_cfg.banks_high[3*(win-3) +: 3], 4'b0};
      end
      if (r.shadow_select == SHADOW_NONE) begin
         thresh = LEVEL_MAX;
      end else begin
         thresh = mix_cfg.shadow_levels[LEVEL_W*(int'(r.shadow_select)-1) +: LEVEL_W];
      end
      res.shadow_out = (pri[win] < thresh) ? r.shadow_select : SHADOW_NONE;
      return res;
   endfunction

   function automatic req_type make_request(logic [8:0] p0, logic [8:0] p1, logic [8:0] p2,
                                            logic [7:0] p3, logic [7:0] p4, logic [5:0] e0,
                                            logic [5:0] e1, logic [5:0] e2, logic [1:0] sh);
      req_type r;
      r.layer0_pixel = p0;
      r.layer1_pixel = p1;
      r.layer2_pixel = p2;
      r.layer3_pixel = p3;
      r.layer4_pixel = p4;
      r.ext_priority0 = e0;
      r.ext_priority1 = e1;
      r.ext_priority2 = e2;
      r.shadow_select = sh;
      return r;
   endfunction

   // Pixel codes lean toward the opacity boundaries: empty, high bits only, low nibble only.
   function automatic logic [8:0] draw_pixel(bit see_through);
      logic [8:0] value;
      case ($urandom_range(0, see_through ? 1 : 3))
         0: value = 9'h000;
         1: value = 9'($urandom) & 9'h1F0;
         2: value = 9'($urandom_range(1, 15));
         default: value = 9'($urandom);
      endcase
      return value;
   endfunction

   // Priorities are often drawn from a narrow range so that ties are common.
   function automatic logic [5:0] draw_level();
      return $urandom_range(0, 1) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
   endfunction

   function automatic req_type random_request();
      bit see_through;
      see_through = ($urandom_range(0, 7) == 0);
      return make_request(draw_pixel(see_through), draw_pixel(see_through),
                          draw_pixel(see_through), 8'(draw_pixel(see_through)),
                          8'(draw_pixel(see_through)), draw_level(), draw_level(),
                          draw_level(), 2'($urandom_range(0, 3)));
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
   endtask

   // One register write: setup cycle, then access cycle; the register takes it at the last edge.
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_LEVELS:     mix_cfg.levels = value[29:0];
         REG_SHADOW:     mix_cfg.shadow_levels = value[17:0];
         REG_BANKS_LOW:  mix_cfg.banks_low = value[5:0];
         REG_BANKS_HIGH: mix_cfg.banks_high = value[5:0];
         REG_OPACITY:    mix_cfg.opacity_swap = value[5:0];
         REG_SRC_ENABLE: mix_cfg.src_enable = value[2:0];
         default: ;
      endcase
   endtask

   task automatic write_setting(logic [31:0] levels, logic [31:0] shadow, logic [31:0] banks_low,
                                logic [31:0] banks_high, logic [31:0] opacity,
                                logic [31:0] src_enable);
      csr_write(REG_LEVELS, levels);
      csr_write(REG_SHADOW, shadow);
      csr_write(REG_BANKS_LOW, banks_low);
      csr_write(REG_BANKS_HIGH, banks_high);
      csr_write(REG_OPACITY, opacity);
      csr_write(REG_SRC_ENABLE, src_enable);
      setting_count++;
      @(negedge clock);
   endtask

   // Waits until every request is taken and every result has come back, then lets the pipe empty.
   task automatic drain_requests();
      while (pending_pixels.size() != 0 || expected_mixes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: offers the oldest pending request and records its expected mix on acceptance.
   always @(posedge clock) begin : request_driver
      req_type taken;
      logic    next_valid;
      int      gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            taken = pending_pixels.pop_front();
            expected_mixes.push_back(resolve_pixel(taken));
            request_count++;
            next_valid = 1'b0;
            gap_left = burst_mode ? 0 : $urandom_range(0, 6);
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pixels.size() != 0) begin
               next_valid = 1'b1;
               req_tdata <= REQ_TDATA_W'(pending_pixels[0]);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Result monitor: checks each accepted result against the oldest expectation and paces tready.
   always @(posedge clock) begin : result_monitor
      rsp_type got;
      rsp_type want;
      logic    next_ready;
      int      stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (expected_mixes.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_tdata, 0);
            end else begin
               want = expected_mixes.pop_front();
               result_count++;
               if (got.top_layer != want.top_layer)
                  report_mismatch("top_layer", got.top_layer, want.top_layer);
               if (got.top_pixel != want.top_pixel)
                  report_mismatch("top_pixel", got.top_pixel, want.top_pixel);
               if (got.top_priority != want.top_priority)
                  report_mismatch("top_priority", got.top_priority, want.top_priority);
               if (got.palette_offset != want.palette_offset)
                  report_mismatch("palette_offset", got.palette_offset, want.palette_offset);
               if (got.shadow_out != want.shadow_out)
                  report_mismatch("shadow_out", got.shadow_out, want.shadow_out);
               if (rsp_tdata[RSP_TDATA_W-1:$bits(rsp_type)] != '0)
                  report_mismatch("tdata padding", rsp_tdata[RSP_TDATA_W-1:$bits(rsp_type)], 0);
            end
            stall_left = burst_mode ? 0 : $urandom_range(0, 6);
         end
         // A long hold-off lets the block fill up and push back on requests.
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   // Watchdog: ends the run when work is outstanding but nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (pending_pixels.size() == 0 && expected_mixes.size() == 0)) begin
         watchdog_cycles <= 0;
      end else if (watchdog_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("[layer_priority_mixer] ERROR");
         $finish;
      end else begin
         watchdog_cycles <= watchdog_cycles + 1;
      end
   end

   initial begin : stimulus
      int          phase;
      int          k;
      logic [29:0] levels;
      mix_cfg.levels = 30'h3FFFFFFF;
      mix_cfg.shadow_levels = '0;
      mix_cfg.banks_low = '0;
      mix_cfg.banks_high = '0;
      mix_cfg.opacity_swap = '0;
      mix_cfg.src_enable = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: external priorities for layers 0-2, every level 63, nibble opacity.
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h00, 8'h00,
                                            6'd0, 6'd0, 6'd0, SHADOW_NONE));
      pending_pixels.push_back(make_request(9'h1FF, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF,
                                            6'd63, 6'd63, 6'd63, SHADOW_SEL3));
      pending_pixels.push_back(make_request(9'h1F0, 9'h0F0, 9'h100, 8'hF0, 8'h10,
                                            6'd10, 6'd5, 6'd20, SHADOW_SEL1));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h00F, 8'h00, 8'h01,
                                            6'd0, 6'd0, 6'd62, SHADOW_SEL2));
      drain_requests();

      // Full-byte opacity everywhere, swap on, distinct banks and shadow thresholds.
      write_setting(32'({6'd2, 6'd7, 6'd40, 6'd7, 6'd7}), 32'({6'd0, 6'd63, 6'd10}), 32'h39,
                    32'h2B, 32'h3F, 32'h0);
      // Layer 1 stronger than layer 0: the two exchange positions.
      pending_pixels.push_back(make_request(9'h0F0, 9'h010, 9'h000, 8'h00, 8'h00,
                                            6'd9, 6'd3, 6'd30, SHADOW_SEL1));
      // Equal priorities with swap on: no exchange, layer 0 keeps the tie.
      pending_pixels.push_back(make_request(9'h080, 9'h020, 9'h000, 8'h00, 8'h00,
                                            6'd5, 6'd5, 6'd5, SHADOW_SEL2));
      // Nothing opaque with the exchange in effect.
      pending_pixels.push_back(make_request(9'h000, 9'h100, 9'h100, 8'h00, 8'h00,
                                            6'd63, 6'd1, 6'd63, SHADOW_SEL3));
      // Only bit 8 set: never counts toward opacity.
      pending_pixels.push_back(make_request(9'h100, 9'h100, 9'h100, 8'h80, 8'h00,
                                            6'd0, 6'd0, 6'd0, SHADOW_SEL1));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h00, 8'h40,
                                            6'd50, 6'd50, 6'd50, SHADOW_SEL3));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h01, 8'h40,
                                            6'd50, 6'd50, 6'd50, SHADOW_SEL2));
      drain_requests();

      // Every level zero and taken from the registers: ties everywhere.
      write_setting(32'h0, 32'h0003F03F, 32'h3F, 32'h3F, 32'h20, 32'h7);
      pending_pixels.push_back(make_request(9'h1FF, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF,
                                            6'd63, 6'd63, 6'd63, SHADOW_SEL1));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h0F, 8'h0F,
                                            6'd0, 6'd0, 6'd0, SHADOW_SEL3));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h00, 8'h00,
                                            6'd12, 6'd34, 6'd56, SHADOW_SEL2));
      pending_pixels.push_back(make_request(9'h000, 9'h0F0, 9'h001, 8'h00, 8'h00,
                                            6'd0, 6'd0, 6'd0, SHADOW_NONE));
      drain_requests();

      // Bits above each register's width and writes past the last register must be ignored.
      write_setting(32'hC000_0000 | 32'({6'd63, 6'd0, 6'd63, 6'd0, 6'd63}),
                    32'hFFFC_0000 | 32'({6'd63, 6'd32, 6'd1}), 32'hFFFF_FFC6, 32'hFFFF_FFD1,
                    32'hFFFF_FFD5, 32'hFFFF_FFFA);
      csr_write(REG_SPARE6, 32'hFFFF_FFFF);
      csr_write(REG_SPARE7, 32'h0000_0000);
      @(negedge clock);
      pending_pixels.push_back(make_request(9'h1FF, 9'h000, 9'h0F0, 8'hF0, 8'h0F,
                                            6'd31, 6'd0, 6'd63, SHADOW_SEL2));
      pending_pixels.push_back(make_request(9'h000, 9'h000, 9'h000, 8'h00, 8'h00,
                                            6'd63, 6'd0, 6'd0, SHADOW_SEL1));
      pending_pixels.push_back(make_request(9'h0F0, 9'h1FF, 9'h000, 8'hFF, 8'hFF,
                                            6'd0, 6'd63, 6'd0, SHADOW_SEL3));
      drain_requests();

      // Random phases, each under a fresh register setting.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: levels = '0;
            1: levels = 30'h3FFFFFFF;
            2: begin
               for (k = 0; k < NUM_LAYERS; k++) levels[LEVEL_W*k +: LEVEL_W] = draw_level();
            end
            default: levels = 30'($urandom);
         endcase
         write_setting({2'($urandom_range(0, 3)), levels}, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
         burst_mode = (phase == 2);
         for (k = 0; k < PHASE_REQUESTS; k++) pending_pixels.push_back(random_request());
         if (phase == 4 || phase == 6) long_hold_req = 1'b1;
         drain_requests();
         burst_mode = 1'b0;
      end

      $display("Mixed %0d requests over %0d register settings; %0d results checked.",
               request_count, setting_count, result_count);
      if (error_count == 0) begin
         $display("[layer_priority_mixer] OK");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("[layer_priority_mixer] ERROR");
      end
      $finish;
   end

endmodule
